@@ hdl/svl_pkg.sv @@
// Package for the sorted value list: widths, operation and status codes,
// sequencer states and the result record.
// No dependencies.
package svl_pkg;

	localparam int CAPACITY_DEF = 32;
	localparam int DATA_W       = 32;
	localparam int POS_W        = 5;
	localparam int STATUS_W     = 3;
	localparam int OPCODE_W     = 2;

	// Operation codes carried on the input stream
	typedef enum logic [OPCODE_W-1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_LIST   = 2'd2
	} op_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_ADDED    = 3'd0,
		ST_FULL     = 3'd1,
		ST_REMOVED  = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_EMPTY    = 3'd4,
		ST_LISTED   = 3'd5
	} status_t;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_INS_LAST,
		S_DEL_SCAN,
		S_DEL_SHIFT,
		S_LIST,
		S_RESP
	} state_t;

	// One result item
	typedef struct packed {
		status_t              status;
		logic [DATA_W-1:0]    value;
		logic [POS_W-1:0]     position;
		logic                 last;
	} res_t;

endpackage

@@ hdl/sorted_value_list.sv @@
// Top level of the sorted value list: stream ports, output register,
// sequencer and entry memory.
// Depends on svl_pkg, svl_mem and svl_seq.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+--------------------------------------
//  s_*     | in  | s_tvalid/s_tready | tdata: opcode, value
//  m_*     | out | m_tvalid/m_tready | tdata: entry_value, position;
//          |     |                   | tuser: status; tlast: last
//
// Insert walks down from the top, shifting entries up; delete scans up
// to the match, then shifts the entries above it down; list reads each
// entry in turn, with at most one memory read and one write per cycle.
// Reset empties the list at once; the memory needs no clearing.
// A stalled output holds one result in the output register and then
// stalls the sequencer; no input is taken until an item is finished.
module sorted_value_list #(
	parameter int CAPACITY = svl_pkg::CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [1:0] opcode, [33:2] value, [39:34] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] entry_value, [36:32] position, [39:37] zero
	output logic [2:0]  m_tuser,   // [2:0] status
	output logic        m_tlast
);
	import svl_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	logic              res_valid;
	logic              res_ready;
	res_t              res;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [DATA_W-1:0] rd_data;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [DATA_W-1:0] wr_data;

	logic              out_valid_q;
	res_t              out_q;

	svl_seq #(
		.CAPACITY (CAPACITY),
		.AW       (AW),
		.CW       (CW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (op_t'(s_tdata[1:0])),
		.in_value  (s_tdata[33:2]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	svl_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// output register: takes a result whenever empty or being drained
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_q.position, out_q.value};
	assign m_tuser  = out_q.status;
	assign m_tlast  = out_q.last;

endmodule

@@ hdl/svl_mem.sv @@
// Entry storage for the sorted value list: one write port, one read port
// with registered read data that holds while the read is not enabled.
// Depends on svl_pkg.
module svl_mem #(
	parameter int DEPTH = svl_pkg::CAPACITY_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       rd_en,
	input  logic [AW-1:0]              rd_addr,
	output logic [svl_pkg::DATA_W-1:0] rd_data,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic [svl_pkg::DATA_W-1:0] wr_data
);
	import svl_pkg::*;

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read port, data registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ hdl/svl_seq.sv @@
// Sequencer for the sorted value list: walks the entry memory one entry
// per cycle, pausing while a listed result stalls, through a single compare unit to insert, delete and list.
// Depends on svl_pkg; drives svl_mem.
module svl_seq #(
	parameter int CAPACITY = svl_pkg::CAPACITY_DEF,
	parameter int AW       = $clog2(CAPACITY),
	parameter int CW       = $clog2(CAPACITY + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// command side
	input  logic                       in_valid,
	output logic                       in_ready,
	input  svl_pkg::op_t               in_op,
	input  logic [svl_pkg::DATA_W-1:0] in_value,
	// result side
	output logic                       res_valid,
	input  logic                       res_ready,
	output svl_pkg::res_t              res,
	// memory side
	output logic                       rd_en,
	output logic [AW-1:0]              rd_addr,
	input  logic [svl_pkg::DATA_W-1:0] rd_data,
	output logic                       wr_en,
	output logic [AW-1:0]              wr_addr,
	output logic [svl_pkg::DATA_W-1:0] wr_data
);
	import svl_pkg::*;

	state_t            state_q, state_d;
	logic [CW-1:0]     cnt_q, cnt_d;
	logic [AW-1:0]     idx_q, idx_d;
	logic [AW-1:0]     p_q, p_d;
	logic [DATA_W-1:0] val_q, val_d;
	res_t              res_q, res_d;

	logic              at_last;
	logic              rd_less;
	logic              rd_equal;

	// low bits of an index as a result position
	function automatic logic [POS_W-1:0] to_pos(input logic [AW-1:0] i);
		logic [AW+POS_W-1:0] w;
		w = {{POS_W{1'b0}}, i};
		return w[POS_W-1:0];
	endfunction

	// shared compare unit on the word just read
	assign rd_less  = $signed(rd_data) < $signed(val_q);
	assign rd_equal = rd_data == val_q;
	assign at_last  = CW'(idx_q) == (cnt_q - CW'(1));

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		p_q   <= p_d;
		val_q <= val_d;
		res_q <= res_d;
	end

	// next state and outputs
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		idx_d     = idx_q;
		p_d       = p_q;
		val_d     = val_q;
		res_d     = res_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		res       = res_q;
		rd_en     = 1'b0;
		rd_addr   = idx_q;
		wr_en     = 1'b0;
		wr_addr   = idx_q;
		wr_data   = val_q;

		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					val_d = in_value;
					res_d = '{status: ST_EMPTY, value: in_value, position: '0, last: 1'b1};
					case (in_op)
						OP_INSERT: begin
							if (cnt_q == CW'(CAPACITY)) begin
								res_d.status = ST_FULL;
								state_d      = S_RESP;
							end else if (cnt_q == '0) begin
								wr_en        = 1'b1;
								wr_addr      = '0;
								wr_data      = in_value;
								cnt_d        = cnt_q + CW'(1);
								res_d.status = ST_ADDED;
								state_d      = S_RESP;
							end else begin
								// walk down from the top, shifting up as we go
								rd_en   = 1'b1;
								rd_addr = AW'(cnt_q - CW'(1));
								idx_d   = AW'(cnt_q);
								state_d = S_INS;
							end
						end
						OP_DELETE: begin
							if (cnt_q == '0) begin
								state_d = S_RESP;
							end else begin
								rd_en   = 1'b1;
								rd_addr = '0;
								idx_d   = '0;
								state_d = S_DEL_SCAN;
							end
						end
						OP_LIST: begin
							if (cnt_q == '0) begin
								res_d.value = '0;
								state_d     = S_RESP;
							end else begin
								rd_en   = 1'b1;
								rd_addr = '0;
								idx_d   = '0;
								state_d = S_LIST;
							end
						end
						default: begin
							// unused code: no result
							state_d = S_IDLE;
						end
					endcase
				end
			end

			// rd_data holds entry idx-1; slot idx is free
			S_INS: begin
				wr_en   = 1'b1;
				wr_addr = idx_q;
				if (!rd_less) begin
					wr_data = rd_data;
					if (idx_q == AW'(1)) begin
						idx_d   = '0;
						state_d = S_INS_LAST;
					end else begin
						rd_en   = 1'b1;
						rd_addr = idx_q - AW'(2);
						idx_d   = idx_q - AW'(1);
					end
				end else begin
					wr_data        = val_q;
					cnt_d          = cnt_q + CW'(1);
					res_d.status   = ST_ADDED;
					res_d.position = to_pos(idx_q);
					state_d        = S_RESP;
				end
			end

			// every entry was not smaller: value goes to the bottom
			S_INS_LAST: begin
				wr_en          = 1'b1;
				wr_addr        = '0;
				wr_data        = val_q;
				cnt_d          = cnt_q + CW'(1);
				res_d.status   = ST_ADDED;
				res_d.position = '0;
				state_d        = S_RESP;
			end

			// rd_data holds entry idx; look for the first one not smaller
			S_DEL_SCAN: begin
				if (rd_less) begin
					if (at_last) begin
						res_d.status = ST_NOTFOUND;
						state_d      = S_RESP;
					end else begin
						rd_en   = 1'b1;
						rd_addr = idx_q + AW'(1);
						idx_d   = idx_q + AW'(1);
					end
				end else if (rd_equal) begin
					p_d = idx_q;
					if (at_last) begin
						cnt_d          = cnt_q - CW'(1);
						res_d.status   = ST_REMOVED;
						res_d.position = to_pos(idx_q);
						state_d        = S_RESP;
					end else begin
						rd_en   = 1'b1;
						rd_addr = idx_q + AW'(1);
						idx_d   = idx_q + AW'(1);
						state_d = S_DEL_SHIFT;
					end
				end else begin
					res_d.status = ST_NOTFOUND;
					state_d      = S_RESP;
				end
			end

			// rd_data holds entry idx; move it down one slot
			S_DEL_SHIFT: begin
				wr_en   = 1'b1;
				wr_addr = idx_q - AW'(1);
				wr_data = rd_data;
				if (at_last) begin
					cnt_d          = cnt_q - CW'(1);
					res_d.status   = ST_REMOVED;
					res_d.position = to_pos(p_q);
					state_d        = S_RESP;
				end else begin
					rd_en   = 1'b1;
					rd_addr = idx_q + AW'(1);
					idx_d   = idx_q + AW'(1);
				end
			end

			// rd_data holds entry idx; read data holds while stalled
			S_LIST: begin
				res_valid = 1'b1;
				res       = '{status: ST_LISTED, value: rd_data,
					position: to_pos(idx_q), last: at_last};
				if (res_ready) begin
					if (at_last) begin
						state_d = S_IDLE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = idx_q + AW'(1);
						idx_d   = idx_q + AW'(1);
					end
				end
			end

			S_RESP: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ tb/testbench.sv @@
// Testbench for sorted_value_list: drives insert, delete, list and unused-opcode transfers with
// random gaps on both streams and checks every result against a queue-based copy of the list.
// Depends on svl_pkg and the sorted_value_list RTL.
module testbench;
	import svl_pkg::*;

	localparam int CAP            = CAPACITY_DEF;
	localparam int STALL_LIMIT    = 3000;
	localparam int MAX_REPORTS    = 40;
	localparam int INT_MIN        = 32'h8000_0000;
	localparam int INT_MAX        = 32'h7fff_ffff;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// One expected result
	typedef struct {
		status_t             status;
		logic [DATA_W-1:0]   value;
		logic [POS_W-1:0]    position;
		logic                last;
	} result_rec_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	int          held_values[$];      // sorted copy of the list contents
	result_rec_t pending_results[$];  // results still owed by the block
	int          err_count    = 0;
	int          quiet_cycles = 0;
	int          rx_hold      = 0;
	bit          tx_gaps      = 1'b1;
	bit          rx_gaps      = 1'b1;

	always #5 clk = ~clk;

	sorted_value_list dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Mostly no gap, often a short one, now and then a long one
	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Narrow values give duplicates, a few extremes, the rest full range
	function automatic int pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return int'($urandom_range(0, 15)) - 8;
		if (r == 4) begin
			case ($urandom_range(0, 3))
				0: return INT_MIN;
				1: return INT_MAX;
				2: return 0;
				default: return -1;
			endcase
		end
		return $urandom;
	endfunction

	// A value currently in the list, if there is one
	function automatic int pick_held();
		if (held_values.size() == 0)
			return pick_value();
		return held_values[$urandom_range(0, held_values.size() - 1)];
	endfunction

	// Count of entries strictly below v
	function automatic int lower_position(int v);
		int p;
		p = 0;
		while (p < held_values.size() && held_values[p] < v)
			p++;
		return p;
	endfunction

	task automatic expect_result(status_t st, int v, int pos, logic last);
		result_rec_t rec;
		rec.status   = st;
		rec.value    = v;
		rec.position = pos[POS_W-1:0];
		rec.last     = last;
		pending_results.push_back(rec);
	endtask

	// Update the list copy for one accepted transfer and queue its results
	task automatic apply_to_list(logic [1:0] op, int v);
		int p;
		case (op)
			OP_INSERT: begin
				if (held_values.size() >= CAP) begin
					expect_result(ST_FULL, v, 0, 1'b1);
				end else begin
					p = lower_position(v);
					held_values.insert(p, v);
					expect_result(ST_ADDED, v, p, 1'b1);
				end
			end
			OP_DELETE: begin
				if (held_values.size() == 0) begin
					expect_result(ST_EMPTY, v, 0, 1'b1);
				end else begin
					p = lower_position(v);
					if (p >= held_values.size() || held_values[p] != v) begin
						expect_result(ST_NOTFOUND, v, 0, 1'b1);
					end else begin
						held_values.delete(p);
						expect_result(ST_REMOVED, v, p, 1'b1);
					end
				end
			end
			OP_LIST: begin
				if (held_values.size() == 0)
					expect_result(ST_EMPTY, 0, 0, 1'b1);
				else
					for (int i = 0; i < held_values.size(); i++)
						expect_result(ST_LISTED, held_values[i], i,
							i == held_values.size() - 1);
			end
			default: ;  // unused opcode: no result, no change
		endcase
	endtask

	task automatic report_mismatch(string msg);
		// keep the log short if the block goes badly wrong
		if (err_count < MAX_REPORTS)
			$display("%0t: mismatch: %s", $time, msg);
		err_count++;
	endtask

	// Input side: predict on every accepted transfer
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			apply_to_list(s_tdata[1:0], s_tdata[33:2]);
	end

	// Output side: compare every accepted transfer with the oldest expectation
	always @(posedge clk) begin : check_results
		result_rec_t want;
		if (m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result status %0d value %0d pos %0d",
					m_tuser, $signed(m_tdata[31:0]), m_tdata[36:32]));
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.status)
					report_mismatch($sformatf("status %0d, want %0d",
						m_tuser, want.status));
				if (m_tdata[31:0] !== want.value)
					report_mismatch($sformatf("entry_value %0d, want %0d",
						$signed(m_tdata[31:0]), $signed(want.value)));
				if (m_tdata[36:32] !== want.position)
					report_mismatch($sformatf("position %0d, want %0d",
						m_tdata[36:32], want.position));
				if (m_tlast !== want.last)
					report_mismatch($sformatf("tlast %0b, want %0b",
						m_tlast, want.last));
			end
		end
	end

	// Watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[sorted_value_list] ERROR");
			$finish;
		end
	end

	// Receiver: random stalls on m_tready
	always @(negedge clk) begin : drive_ready
		int g;
		if (rx_hold > 0) begin
			rx_hold--;
		end else begin
			g = rx_gaps ? gap_length() : 0;
			if (g == 0) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				rx_hold = g - 1;
			end
		end
	end

	// Send one item; entered and left at a falling edge
	task automatic send_op(logic [1:0] op, int v);
		int gap;
		gap = tx_gaps ? gap_length() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, v[31:0], op};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic test_empty_table();
		send_op(OP_LIST, 0);
		send_op(OP_DELETE, INT_MIN);
		send_op(OP_DELETE, INT_MAX);
		send_op(OP_UNUSED, $urandom);
		send_op(OP_LIST, $urandom);
	endtask

	// Deleting the only entry must leave an empty list
	task automatic test_single_entry();
		send_op(OP_INSERT, 5);
		send_op(OP_LIST, 0);
		send_op(OP_DELETE, 5);
		send_op(OP_LIST, 0);
	endtask

	// Extremes, middle and duplicate inserts, then targeted deletes
	task automatic test_ordering();
		send_op(OP_INSERT, 0);
		send_op(OP_INSERT, INT_MAX);
		send_op(OP_INSERT, INT_MIN);
		send_op(OP_INSERT, -1);
		send_op(OP_INSERT, 0);
		send_op(OP_INSERT, 7);
		send_op(OP_INSERT, INT_MAX);
		send_op(OP_DELETE, 3);
		send_op(OP_DELETE, 0);
		send_op(OP_UNUSED, INT_MIN);
		send_op(OP_LIST, -1);
		send_op(OP_DELETE, INT_MIN);
		send_op(OP_DELETE, INT_MAX);
		send_op(OP_DELETE, INT_MAX);
		send_op(OP_LIST, 0);
	endtask

	// Fill to capacity, hit the full case, list a full table, then drain down to two entries
	task automatic test_fill_and_drain();
		while (held_values.size() < CAP)
			send_op(OP_INSERT, pick_value());
		repeat (3) send_op(OP_INSERT, pick_value());
		send_op(OP_LIST, 0);
		while (held_values.size() > 2) begin
			if ($urandom_range(0, 5) == 0)
				send_op(OP_DELETE, pick_value());
			else
				send_op(OP_DELETE, pick_held());
		end
		send_op(OP_LIST, 0);
	endtask

	task automatic test_random_mix(int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 45)
				send_op(OP_INSERT, pick_value());
			else if (r < 80)
				send_op(OP_DELETE, ($urandom_range(0, 4) == 0) ? pick_value() : pick_held());
			else if (r < 95)
				send_op(OP_LIST, $urandom);
			else
				send_op(OP_UNUSED, $urandom);
		end
	endtask

	// Stretch with both streams running flat out
	task automatic test_back_to_back();
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		test_random_mix(20);
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_empty_table();
		test_single_entry();
		test_ordering();
		test_fill_and_drain();
		test_random_mix(50);
		test_back_to_back();

		// drain, then keep watching for stray results
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (CAP + 8) @(posedge clk);

		if (err_count == 0)
			$display("[sorted_value_list] OK");
		else
			$display("[sorted_value_list] ERROR");
		$finish;
	end

endmodule

@@ sorted_value_list.f @@
hdl/svl_pkg.sv
hdl/svl_mem.sv
hdl/svl_seq.sv
hdl/sorted_value_list.sv
tb/testbench.sv
